/* src/square_wave_channel_with_sweep_unit_assert.svh */
// Assertion macros used by the square wave channel RTL.
`ifndef SQUARE_WAVE_CHANNEL_WITH_SWEEP_UNIT_ASSERT_SVH
`define SQUARE_WAVE_CHANNEL_WITH_SWEEP_UNIT_ASSERT_SVH
`ifndef SYNTH
// Checked on every rising edge while reset is released.
`define SWC_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every rising edge, reset included.
`define SWC_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SWC_ASSERT(name, clk, rst_n, prop, msg)
`define SWC_ASSERT_ALWAYS(name, clk, prop, msg)
`endif
`endif

/* src/swc_pkg.sv */
// Types, codes and constant tables of the square wave channel.
`default_nettype none
package swc_pkg;

    // Item operation codes.
    localparam logic [2:0] MODE_WRITE    = 3'd0;
    localparam logic [2:0] MODE_READ     = 3'd1;
    localparam logic [2:0] MODE_TICK     = 3'd2;
    localparam logic [2:0] MODE_LENGTH   = 3'd3;
    localparam logic [2:0] MODE_SWEEP    = 3'd4;
    localparam logic [2:0] MODE_ENVELOPE = 3'd5;

    // Register indexes after folding the address nibble.
    localparam logic [2:0] REG_SWEEP   = 3'd0;
    localparam logic [2:0] REG_DUTY    = 3'd1;
    localparam logic [2:0] REG_ENV     = 3'd2;
    localparam logic [2:0] REG_FREQ_LO = 3'd3;
    localparam logic [2:0] REG_TRIGGER = 3'd4;

    // The four 8-step duty patterns; step p is bit 7-p.
    localparam logic [7:0] DUTY_TABLE [4] = '{8'h01, 8'h81, 8'h87, 8'h7E};

    typedef struct packed {
        logic [2:0] mode;
        logic [3:0] reg_offset;
        logic [7:0] write_data;
    } item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic [3:0] sample_level;
        logic       length_running;
        logic       channel_on;
    } result_t;

endpackage
`default_nettype wire

/* src/square_wave_channel_with_sweep_unit.sv */
// Top level of the square wave channel with sweep, envelope and length counter.
//
// Pulse sound channel of the classic handheld console (channel 1). Every input item is one
// of: a register write, a register read, one timer tick, or a length, sweep or envelope
// clock from the frame sequencer; modes six and seven change nothing. Each item produces
// exactly one result item carrying the read byte (zero unless the item was a read), the
// current 4-bit output level, whether the length counter is non-zero and whether the
// channel is enabled, all as they stand after the item has been applied. An item is
// registered on entry, applied to the channel state by combinational logic and its result
// is registered on exit, so the block takes one item per clock cycle while the result
// register is free or being emptied; each result then waits in the result register until
// it is taken. The input register keeps accepting while a result waits to be taken; input
// ready drops only when both the input register and the result register are full and
// out_ready is low. After reset all channel state is zero and the channel is off.
`default_nettype none
module square_wave_channel_with_sweep_unit
    import swc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [2:0] mode,
    input  wire logic [3:0] reg_offset,
    input  wire logic [7:0] write_data,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      read_data,
    output logic [3:0]      sample_level,
    output logic            length_running,
    output logic            channel_on
);

    logic    item_valid_reg;
    logic    item_valid_next;
    item_t   item_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t result_reg;
    result_t result_comb;
    logic    advance;

    // The registered item is applied when the result register is free or being emptied.
    assign advance  = item_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !item_valid_reg || advance;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (in_valid && in_ready)
        begin
            item_valid_next = 1'b1;
        end
        else if (advance)
        begin
            item_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    swc_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (advance),
        .item   (item_reg),
        .result (result_comb)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.mode       <= mode;
            item_reg.reg_offset <= reg_offset;
            item_reg.write_data <= write_data;
        end
        if (advance)
        begin
            result_reg <= result_comb;
        end
    end

    assign out_valid      = out_valid_reg;
    assign read_data      = result_reg.read_data;
    assign sample_level   = result_reg.sample_level;
    assign length_running = result_reg.length_running;
    assign channel_on     = result_reg.channel_on;

endmodule
`default_nettype wire

/* src/swc_core.sv */
// Channel state and the single-pass update applied for one item.
`default_nettype none
`include "square_wave_channel_with_sweep_unit_assert.svh"
module swc_core
    import swc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    en,
    input  wire item_t   item,
    output result_t      result
);

    typedef struct packed {
        logic [13:0] period_timer;
        logic [2:0]  duty_position;
        logic [6:0]  length_counter;
        logic [5:0]  length_setting;
        logic        length_enable;
        logic        channel_enabled;
        logic        dac_on;
        logic [1:0]  duty_select;
        logic [10:0] freq_setting;
        logic        trigger_bit;
        logic [3:0]  env_initial;
        logic        env_up;
        logic [2:0]  env_period;
        logic [4:0]  env_countdown;
        logic        env_running;
        logic [3:0]  volume_level;
        logic [2:0]  sweep_shift_amt;
        logic        sweep_down;
        logic [2:0]  sweep_time_setting;
        logic [4:0]  sweep_countdown;
        logic        sweep_active;
        logic [10:0] shadow_freq;
        logic [3:0]  output_level;
    } chan_state_t;

    chan_state_t state_reg;
    chan_state_t state_next;
    logic [2:0]  reg_sel;
    logic [7:0]  rd;
    logic [11:0] nf_first;
    logic [11:0] nf_second;

    function automatic logic [2:0] reg_index(input logic [3:0] off);
        logic [2:0] r;
        unique case (off) inside
            4'd0, 4'd5, 4'd10, 4'd15: r = REG_SWEEP;
            4'd1, 4'd6, 4'd11:        r = REG_DUTY;
            4'd2, 4'd7, 4'd12:        r = REG_ENV;
            4'd3, 4'd8, 4'd13:        r = REG_FREQ_LO;
            default:                  r = REG_TRIGGER;
        endcase
        return r;
    endfunction

    function automatic logic [13:0] reload_period(input logic [10:0] f);
        logic [11:0] d;
        d = 12'd2048 - {1'b0, f};
        return {d, 2'b00};
    endfunction

    // Bit 11 of the result flags a frequency beyond 2047.
    function automatic logic [11:0] sweep_calc(input logic [10:0] sh, input logic [2:0] amt,
                                               input logic down);
        logic [11:0] delta;
        delta = {1'b0, sh >> amt};
        return down ? ({1'b0, sh} - delta) : ({1'b0, sh} + delta);
    endfunction

    assign reg_sel = reg_index(item.reg_offset);

    always_comb
    begin
        state_next = state_reg;
        rd         = '0;
        nf_first   = '0;
        nf_second  = '0;
        if (en)
        begin
            case (item.mode)
                MODE_WRITE:
                begin
                    unique case (reg_sel)
                        REG_SWEEP:
                        begin
                            state_next.sweep_shift_amt    = item.write_data[2:0];
                            state_next.sweep_down         = item.write_data[3];
                            state_next.sweep_time_setting = item.write_data[6:4];
                        end
                        REG_DUTY:
                        begin
                            state_next.duty_select    = item.write_data[7:6];
                            state_next.length_setting = item.write_data[5:0];
                            state_next.length_counter = 7'd64 - {1'b0, item.write_data[5:0]};
                        end
                        REG_ENV:
                        begin
                            state_next.dac_on        = |item.write_data[7:3];
                            state_next.env_initial   = item.write_data[7:4];
                            state_next.volume_level  = item.write_data[7:4];
                            state_next.env_up        = item.write_data[3];
                            state_next.env_period    = item.write_data[2:0];
                            state_next.env_countdown = {2'b00, item.write_data[2:0]};
                        end
                        REG_FREQ_LO:
                        begin
                            state_next.freq_setting[7:0] = item.write_data;
                        end
                        REG_TRIGGER:
                        begin
                            state_next.trigger_bit        = item.write_data[7];
                            state_next.length_enable      = item.write_data[6];
                            state_next.freq_setting[10:8] = item.write_data[2:0];
                            if (item.write_data[7])
                            begin
                                state_next.channel_enabled = 1'b1;
                                if (state_reg.length_counter == '0)
                                begin
                                    state_next.length_counter = 7'd64;
                                end
                                state_next.period_timer  = reload_period(state_next.freq_setting);
                                state_next.env_running   = 1'b1;
                                state_next.env_countdown = {2'b00, state_reg.env_period};
                                state_next.volume_level  = state_reg.env_initial;
                                state_next.shadow_freq   = state_next.freq_setting;
                                state_next.sweep_countdown =
                                    (state_reg.sweep_time_setting != '0) ?
                                    {2'b00, state_reg.sweep_time_setting} : 5'd8;
                                state_next.sweep_active =
                                    (state_reg.sweep_time_setting != '0) ||
                                    (state_reg.sweep_shift_amt != '0);
                                nf_first = sweep_calc(state_next.freq_setting,
                                                      state_reg.sweep_shift_amt,
                                                      state_reg.sweep_down);
                                if ((state_reg.sweep_shift_amt != '0) && nf_first[11])
                                begin
                                    state_next.channel_enabled = 1'b0;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
                MODE_READ:
                begin
                    unique case (reg_sel)
                        REG_SWEEP:   rd = {1'b0, state_reg.sweep_time_setting,
                                           state_reg.sweep_down, state_reg.sweep_shift_amt};
                        REG_DUTY:    rd = {state_reg.duty_select, state_reg.length_setting};
                        REG_ENV:     rd = {state_reg.env_initial, state_reg.env_up,
                                           state_reg.env_period};
                        REG_FREQ_LO: rd = state_reg.freq_setting[7:0];
                        default:     rd = {state_reg.trigger_bit, state_reg.length_enable,
                                           3'b000, state_reg.freq_setting[10:8]};
                    endcase
                end
                MODE_TICK:
                begin
                    if (state_reg.period_timer <= 14'd1)
                    begin
                        state_next.period_timer  = reload_period(state_reg.freq_setting);
                        state_next.duty_position = state_reg.duty_position + 3'd1;
                    end
                    else
                    begin
                        state_next.period_timer = state_reg.period_timer - 14'd1;
                    end
                    state_next.output_level = (state_reg.channel_enabled && state_reg.dac_on) ?
                                              state_reg.volume_level : 4'd0;
                    if (!DUTY_TABLE[state_reg.duty_select][3'd7 - state_next.duty_position])
                    begin
                        state_next.output_level = 4'd0;
                    end
                end
                MODE_LENGTH:
                begin
                    if ((state_reg.length_counter != '0) && state_reg.length_enable)
                    begin
                        state_next.length_counter = state_reg.length_counter - 7'd1;
                        if (state_reg.length_counter == 7'd1)
                        begin
                            state_next.channel_enabled = 1'b0;
                        end
                    end
                end
                MODE_SWEEP:
                begin
                    if (state_reg.sweep_countdown > 5'd1)
                    begin
                        state_next.sweep_countdown = state_reg.sweep_countdown - 5'd1;
                    end
                    else
                    begin
                        state_next.sweep_countdown = (state_reg.sweep_time_setting != '0) ?
                            {2'b00, state_reg.sweep_time_setting} : 5'd8;
                        if (state_reg.sweep_active && (state_reg.sweep_time_setting != '0))
                        begin
                            nf_first = sweep_calc(state_reg.shadow_freq,
                                                  state_reg.sweep_shift_amt,
                                                  state_reg.sweep_down);
                            nf_second = sweep_calc(nf_first[10:0], state_reg.sweep_shift_amt,
                                                   state_reg.sweep_down);
                            if (nf_first[11])
                            begin
                                state_next.channel_enabled = 1'b0;
                            end
                            else if (state_reg.sweep_shift_amt != '0)
                            begin
                                // The new frequency is stored, then checked once more.
                                state_next.shadow_freq  = nf_first[10:0];
                                state_next.freq_setting = nf_first[10:0];
                                if (nf_second[11])
                                begin
                                    state_next.channel_enabled = 1'b0;
                                end
                            end
                        end
                    end
                end
                MODE_ENVELOPE:
                begin
                    if (state_reg.env_countdown > 5'd1)
                    begin
                        state_next.env_countdown = state_reg.env_countdown - 5'd1;
                    end
                    else
                    begin
                        state_next.env_countdown = (state_reg.env_period != '0) ?
                            {2'b00, state_reg.env_period} : 5'd8;
                        if (state_reg.env_running && (state_reg.env_period != '0))
                        begin
                            if (state_reg.env_up && (state_reg.volume_level != 4'd15))
                            begin
                                state_next.volume_level = state_reg.volume_level + 4'd1;
                            end
                            else if (!state_reg.env_up && (state_reg.volume_level != 4'd0))
                            begin
                                state_next.volume_level = state_reg.volume_level - 4'd1;
                            end
                        end
                        if ((state_next.volume_level == 4'd0) ||
                            (state_next.volume_level == 4'd15))
                        begin
                            state_next.env_running = 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        result.read_data      = rd;
        result.sample_level   = state_next.output_level;
        result.length_running = |state_next.length_counter;
        result.channel_on     = state_next.channel_enabled;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `SWC_ASSERT(a_hold_when_idle, clk, rst_n, !en |=> $stable(state_reg), "state changed without an item")
    `SWC_ASSERT(a_length_no_rise, clk, rst_n, (en && (item.mode == MODE_LENGTH)) |=> (state_reg.length_counter <= $past(state_reg.length_counter)), "length clock raised the counter")
    `SWC_ASSERT(a_enable_by_trigger, clk, rst_n, $rose(state_reg.channel_enabled) |-> $past(en && (item.mode == MODE_WRITE) && (reg_sel == REG_TRIGGER) && item.write_data[7]), "channel enabled without a trigger")
    `SWC_ASSERT_ALWAYS(a_length_limit, clk, (!rst_n) || (state_reg.length_counter <= 7'd64), "length counter above 64")

endmodule
`default_nettype wire
